### hw/rtl/hcg_pkg.sv
`timescale 1ns / 1ps
package hcg_pkg;

  typedef struct packed {
    logic [31:0] start_tick;
    logic [15:0] duration;
    logic [31:0] peak_tick;
    logic [15:0] channel;
    logic [23:0] charge;
    logic [13:0] height;
    logic [31:0] tag;
  } member_t;

  localparam int MEMBER_W = $bits(member_t);

  typedef struct packed {
    member_t    mbr;
    logic [7:0] size;
    logic       last_group;
    logic       ovf;
  } res_t;

  // Handshake between sequencer and output staging
  typedef struct packed {
    logic push;
    logic idle;
  } oq_ctl_t;

  typedef struct packed {
    logic push_ok;
    logic pend_valid;
  } oq_sts_t;

  localparam logic [1:0] CFG_TICK_LIMIT     = 2'd0;
  localparam logic [1:0] CFG_CHANNEL_WINDOW = 2'd1;
  localparam logic [1:0] CFG_MIN_GROUP_SIZE = 2'd2;

  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLOT,
    S_DECIDE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_PUT,
    S_MRG_RD,
    S_MRG_WR,
    S_CLOSE,
    S_EMIT_RD,
    S_EMIT_WR,
    S_END,
    S_SHIFT,
    S_NEW,
    S_WB
  } state_t;

endpackage

### hw/rtl/hcg_ram.sv
`timescale 1ns / 1ps
module hcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/hcg_outq.sv
`timescale 1ns / 1ps
module hcg_outq (
  input  logic             clk,
  input  logic             rst,
  input  hcg_pkg::oq_ctl_t ctl,
  input  hcg_pkg::res_t    push_res,
  output hcg_pkg::oq_sts_t sts,
  input  logic             out_ready,
  output logic             out_valid,
  output hcg_pkg::res_t    out_res,
  output logic             out_last
);
  import hcg_pkg::*;

  logic pend_valid;
  res_t pend;
  logic out_free;

  // Pending stage holds the newest result until it is known whether it ends the run.
  assign out_free = !out_valid || out_ready;
  assign sts.push_ok = !pend_valid || out_free;
  assign sts.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (ctl.push && sts.push_ok) begin
      pend <= push_res;
      pend_valid <= 1'b1;
      if (pend_valid) begin
        out_res <= pend;
        out_last <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end else if (ctl.idle && pend_valid && out_free) begin
      out_res <= pend;
      out_last <= 1'b1;
      out_valid <= 1'b1;
      pend_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### hw/rtl/hcg_ctrl.sv
`timescale 1ns / 1ps
module hcg_ctrl #(
  parameter int MAX_CLUSTERS = 4,
  parameter int MAX_MEMBERS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      tick_limit,
  input  logic [11:0]      channel_window,
  input  logic [7:0]       min_group_size,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_flush,
  input  hcg_pkg::member_t in_hit,
  output hcg_pkg::oq_ctl_t oq_ctl,
  input  hcg_pkg::oq_sts_t oq_sts,
  output hcg_pkg::res_t    push_res
);
  import hcg_pkg::*;

  localparam int C = MAX_CLUSTERS;
  localparam int M = MAX_MEMBERS;
  localparam int SW = (C > 1) ? $clog2(C) : 1;
  localparam int CW = $clog2(C + 1);
  localparam int MW = $clog2(M + 1);
  localparam int DEPTH = C * M;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t state, state_next;

  // Slot table
  logic          slot_valid [C];
  logic [MW-1:0] slot_cnt [C];
  logic [32:0]   slot_end [C];
  logic          slot_ovf [C];
  logic [SW-1:0] order [C];
  logic [SW-1:0] new_order [C];
  logic [CW-1:0] open_cnt;
  logic [CW-1:0] nk;
  logic [CW-1:0] k;

  // Item and walk registers
  member_t       hit;
  logic          flush;
  logic [SW-1:0] s;
  logic [SW-1:0] t;
  logic [MW-1:0] m;
  logic          tgt_valid;
  logic          new_mode;
  logic          forced;
  logic [MW-1:0] tgt_cnt;
  logic [32:0]   tgt_end;
  logic          tgt_ovf;

  // Member store port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [MEMBER_W-1:0]  ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [MEMBER_W-1:0]  ram_rdata;
  member_t              rd_m;

  logic [MW-1:0] cur_cnt;
  logic [32:0]   cur_end;
  logic          cur_ovf;
  logic [32:0]   hit_st;
  logic          late;
  logic [15:0]   ch_diff;
  logic          ch_match;
  logic          big_enough;
  logic          tgt_full;
  logic [32:0]   put_end;
  logic [32:0]   mrg_end;
  logic [SW-1:0] free_idx;
  state_t        after_close;

  hcg_ram #(.WIDTH(MEMBER_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_m = member_t'(ram_rdata);

  function automatic logic [AW-1:0] maddr(input logic [SW-1:0] sl, input logic [MW-1:0] mi);
    maddr = AW'(32'(sl) * 32'(M) + 32'(mi));
  endfunction

  assign cur_cnt = slot_cnt[s];
  assign cur_end = slot_end[s];
  assign cur_ovf = slot_ovf[s];
  assign hit_st = {1'b0, hit.start_tick};
  assign late = (hit_st > cur_end) && ((hit_st - cur_end) > {17'b0, tick_limit});
  assign ch_diff = (rd_m.channel > hit.channel) ? rd_m.channel - hit.channel
                                                : hit.channel - rd_m.channel;
  assign ch_match = ch_diff <= {4'b0, channel_window};
  assign big_enough = 8'(cur_cnt) >= min_group_size;
  assign tgt_full = tgt_cnt >= MW'(M);
  assign put_end = ({1'b0, hit.start_tick} + {17'b0, hit.duration} > tgt_end) ?
                   {1'b0, hit.start_tick} + {17'b0, hit.duration} : tgt_end;
  assign mrg_end = ({1'b0, rd_m.start_tick} + {17'b0, rd_m.duration} > tgt_end) ?
                   {1'b0, rd_m.start_tick} + {17'b0, rd_m.duration} : tgt_end;
  assign after_close = forced ? S_SHIFT : S_SLOT;

  always_comb begin
    free_idx = '0;
    for (int i = C - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx = SW'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid && in_ready) state_next = S_SLOT;
      S_SLOT:     state_next = (k == open_cnt) ? S_END : S_DECIDE;
      S_DECIDE:   state_next = (flush || late) ? S_CLOSE : S_SCAN_RD;
      S_SCAN_RD:  state_next = (m == cur_cnt) ? S_SLOT : S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (ch_match) state_next = tgt_valid ? S_MRG_RD : S_PUT;
        else state_next = S_SCAN_RD;
      end
      S_PUT:      state_next = new_mode ? S_WB : S_SLOT;
      S_MRG_RD:   state_next = (m == cur_cnt) ? S_SLOT : S_MRG_WR;
      S_MRG_WR:   state_next = S_MRG_RD;
      S_CLOSE:    state_next = big_enough ? S_EMIT_RD : after_close;
      S_EMIT_RD:  state_next = (m == cur_cnt) ? after_close : S_EMIT_WR;
      S_EMIT_WR:  if (oq_sts.push_ok) state_next = S_EMIT_RD;
      S_END: begin
        if (flush) state_next = S_IDLE;
        else if (tgt_valid) state_next = S_WB;
        else if (nk >= CW'(C)) state_next = S_CLOSE;
        else state_next = S_NEW;
      end
      S_SHIFT:    state_next = S_NEW;
      S_NEW:      state_next = S_PUT;
      S_WB:       state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = (state == S_IDLE) && !oq_sts.pend_valid;
    oq_ctl.push = (state == S_EMIT_WR);
    oq_ctl.idle = (state == S_IDLE);
    push_res.mbr = rd_m;
    push_res.size = 8'(cur_cnt);
    push_res.last_group = (MW'(m + MW'(1)) == cur_cnt);
    push_res.ovf = forced || cur_ovf;
    ram_re = 1'b0;
    ram_raddr = maddr(s, m);
    ram_we = 1'b0;
    ram_waddr = maddr(t, tgt_cnt);
    ram_wdata = hit;
    case (state)
      S_SCAN_RD, S_MRG_RD, S_EMIT_RD: ram_re = (m != cur_cnt);
      S_PUT:    ram_we = !tgt_full;
      S_MRG_WR: begin
        ram_we = !tgt_full;
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      open_cnt <= '0;
      for (int i = 0; i < C; i++) begin
        slot_valid[i] <= 1'b0;
        slot_cnt[i] <= '0;
        slot_end[i] <= '0;
        slot_ovf[i] <= 1'b0;
      end
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            hit <= in_hit;
            flush <= in_flush;
            k <= '0;
            nk <= '0;
            tgt_valid <= 1'b0;
            new_mode <= 1'b0;
            forced <= 1'b0;
          end
        end
        S_SLOT: if (k != open_cnt) s <= order[k[SW-1:0]];
        S_DECIDE: m <= '0;
        S_SCAN_RD: begin
          if (m == cur_cnt) begin
            new_order[nk[SW-1:0]] <= s;
            nk <= nk + CW'(1);
            k <= k + CW'(1);
          end
        end
        S_SCAN_CMP: begin
          if (ch_match) begin
            m <= '0;
            if (!tgt_valid) begin
              t <= s;
              tgt_valid <= 1'b1;
              tgt_cnt <= cur_cnt;
              tgt_end <= cur_end;
              tgt_ovf <= cur_ovf;
            end
          end else begin
            m <= m + MW'(1);
          end
        end
        S_PUT: begin
          if (tgt_full) begin
            tgt_ovf <= 1'b1;
          end else begin
            tgt_cnt <= tgt_cnt + MW'(1);
            tgt_end <= put_end;
          end
          if (!new_mode) begin
            new_order[nk[SW-1:0]] <= t;
            nk <= nk + CW'(1);
            k <= k + CW'(1);
          end
        end
        S_MRG_RD: begin
          if (m == cur_cnt) begin
            // Fold the merged cluster's flag into the target and drop the slot
            tgt_ovf <= tgt_ovf | cur_ovf;
            slot_valid[s] <= 1'b0;
            slot_cnt[s] <= '0;
            slot_end[s] <= '0;
            slot_ovf[s] <= 1'b0;
            k <= k + CW'(1);
          end
        end
        S_MRG_WR: begin
          if (tgt_full) begin
            tgt_ovf <= 1'b1;
          end else begin
            tgt_cnt <= tgt_cnt + MW'(1);
            tgt_end <= mrg_end;
          end
          m <= m + MW'(1);
        end
        S_CLOSE: begin
          m <= '0;
          if (!big_enough) begin
            slot_valid[s] <= 1'b0;
            slot_cnt[s] <= '0;
            slot_end[s] <= '0;
            slot_ovf[s] <= 1'b0;
            if (!forced) k <= k + CW'(1);
          end
        end
        S_EMIT_RD: begin
          if (m == cur_cnt) begin
            slot_valid[s] <= 1'b0;
            slot_cnt[s] <= '0;
            slot_end[s] <= '0;
            slot_ovf[s] <= 1'b0;
            if (!forced) k <= k + CW'(1);
          end
        end
        S_EMIT_WR: if (oq_sts.push_ok) m <= m + MW'(1);
        S_END: begin
          if (flush) begin
            open_cnt <= '0;
          end else begin
            for (int i = 0; i < C; i++) begin
              order[i] <= new_order[i];
            end
            open_cnt <= nk;
            if (!tgt_valid && nk >= CW'(C)) begin
              s <= new_order[0];
              forced <= 1'b1;
            end
          end
        end
        S_SHIFT: begin
          for (int i = 0; i < C - 1; i++) begin
            order[i] <= order[i + 1];
          end
          open_cnt <= open_cnt - CW'(1);
        end
        S_NEW: begin
          t <= free_idx;
          order[open_cnt[SW-1:0]] <= free_idx;
          open_cnt <= open_cnt + CW'(1);
          slot_valid[free_idx] <= 1'b1;
          tgt_cnt <= '0;
          tgt_end <= '0;
          tgt_ovf <= 1'b0;
          new_mode <= 1'b1;
        end
        S_WB: begin
          slot_cnt[t] <= tgt_cnt;
          slot_end[t] <= tgt_end;
          slot_ovf[t] <= tgt_ovf;
        end
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/hit_cluster_grouper_top.sv
`timescale 1ns / 1ps
// Hit cluster grouper.
// Input channel (in_valid/in_ready) takes one item per handshake: a hit
// (req_type 0) with its time, channel and carried data, or a flush (req_type 1).
// Output channel (out_valid/out_ready) delivers one item per emitted cluster
// member, cluster by cluster in member order; last_of_run marks the final item
// caused by one input item.
// Configuration: write cfg_wdata to register cfg_addr while cfg_we is high
// (0 tick_limit, 1 channel_window, 2 min_group_size); only while idle.
// Walk: an item walks the open clusters oldest first. Each member goes through
// the registered member store each time it is scanned, copied in a merge or
// emitted, and an emission also waits out receiver stalls. One item at a time.
// The final result of an item sits in a pending stage until the walk ends;
// the next item is taken once that result has moved to the output register.
// A stalled receiver holds the walk at the next emission, nothing is lost.
// Reset clears all clusters and loads the register defaults (100, 20, 1).
module hit_cluster_grouper_top #(
  parameter int MAX_CLUSTERS = 4,
  parameter int MAX_MEMBERS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [31:0] start_tick,
  input  logic [15:0] over_threshold_ticks,
  input  logic [31:0] peak_tick,
  input  logic [15:0] wire_channel,
  input  logic [23:0] charge_sum,
  input  logic [13:0] peak_height,
  input  logic [31:0] hit_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_start_tick,
  output logic [15:0] out_over_threshold,
  output logic [31:0] out_peak_tick,
  output logic [15:0] out_channel,
  output logic [23:0] out_charge,
  output logic [13:0] out_peak_height,
  output logic [31:0] out_tag,
  output logic [7:0]  group_size,
  output logic        last_of_group,
  output logic        last_of_run,
  output logic        overflowed
);
  import hcg_pkg::*;

  logic [15:0] tick_limit;
  logic [11:0] channel_window;
  logic [7:0]  min_group_size;
  member_t     in_hit;
  oq_ctl_t     oq_ctl;
  oq_sts_t     oq_sts;
  res_t        push_res;
  res_t        out_res;

  // Configuration registers: hold until written
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_limit <= 16'd100;
      channel_window <= 12'd20;
      min_group_size <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TICK_LIMIT:     tick_limit <= cfg_wdata;
        CFG_CHANNEL_WINDOW: channel_window <= cfg_wdata[11:0];
        CFG_MIN_GROUP_SIZE: min_group_size <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_hit.start_tick = start_tick;
  assign in_hit.duration = over_threshold_ticks;
  assign in_hit.peak_tick = peak_tick;
  assign in_hit.channel = wire_channel;
  assign in_hit.charge = charge_sum;
  assign in_hit.height = peak_height;
  assign in_hit.tag = hit_tag;

  // Cluster table walk and member store
  hcg_ctrl #(.MAX_CLUSTERS(MAX_CLUSTERS), .MAX_MEMBERS(MAX_MEMBERS)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .tick_limit     (tick_limit),
    .channel_window (channel_window),
    .min_group_size (min_group_size),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_flush       (req_type == REQ_FLUSH),
    .in_hit         (in_hit),
    .oq_ctl         (oq_ctl),
    .oq_sts         (oq_sts),
    .push_res       (push_res)
  );

  // Pending stage and output register
  hcg_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .ctl       (oq_ctl),
    .push_res  (push_res),
    .sts       (oq_sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_last  (last_of_run)
  );

  assign out_start_tick = out_res.mbr.start_tick;
  assign out_over_threshold = out_res.mbr.duration;
  assign out_peak_tick = out_res.mbr.peak_tick;
  assign out_channel = out_res.mbr.channel;
  assign out_charge = out_res.mbr.charge;
  assign out_peak_height = out_res.mbr.height;
  assign out_tag = out_res.mbr.tag;
  assign group_size = out_res.size;
  assign last_of_group = out_res.last_group;
  assign overflowed = out_res.ovf;

  // The run always ends on the last member of a cluster
  a_run_ends_group: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_run) |-> last_of_group)
    else $error("run ended inside a cluster");

  // One item at a time: no accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while walk busy");

  // A new item never starts while a result still waits in the pending stage
  a_pend_drained: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !oq_sts.pend_valid)
    else $error("item accepted with pending result");

  // Results enter staging only when there is room
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (oq_ctl.push && !oq_sts.push_ok) |=> oq_ctl.push)
    else $error("emission advanced without room");

endmodule

### tb/sv/hit_cluster_grouper_top_test.sv
`timescale 1ns / 1ps
module hit_cluster_grouper_top_test;
  import hcg_pkg::*;

  localparam int NCL = 4;
  localparam int NMB = 8;
  // Drain wait after the last expected item, with a wide margin for the walk.
  localparam int DRAIN_CYCLES = 200;
  // Longest quiet stretch: a long receiver hold plus a full emission at max stalls.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 500;
  localparam logic REQ_HIT = 1'b0;

  typedef struct packed {
    logic    req;
    member_t hit;
  } hit_item_t;

  typedef struct packed {
    member_t    mbr;
    logic [7:0] size;
    logic       last_grp;
    logic       last_run;
    logic       ovf;
  } member_out_t;

  // Directed row: item plus the number of results it must cause (-1 = predictor only)
  typedef struct {
    hit_item_t item;
    int        n_results;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [31:0] start_tick = '0;
  logic [15:0] over_threshold_ticks = '0;
  logic [31:0] peak_tick = '0;
  logic [15:0] wire_channel = '0;
  logic [23:0] charge_sum = '0;
  logic [13:0] peak_height = '0;
  logic [31:0] hit_tag = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_start_tick;
  logic [15:0] out_over_threshold;
  logic [31:0] out_peak_tick;
  logic [15:0] out_channel;
  logic [23:0] out_charge;
  logic [13:0] out_peak_height;
  logic [31:0] out_tag;
  logic [7:0]  group_size;
  logic        last_of_group;
  logic        last_of_run;
  logic        overflowed;

  hit_cluster_grouper_top dut (.*);

  always #1 clk = ~clk;

  // Shadow copy of the cluster table and registers
  logic [15:0] tick_lim;
  logic [11:0] chan_win;
  logic [7:0]  min_size;
  logic        cl_valid [NCL];
  int          cl_order [NCL];
  int          open_n;
  int          cl_count [NCL];
  logic [32:0] cl_end [NCL];
  logic        cl_ovf [NCL];
  member_t     cl_mbr [NCL*NMB];

  member_out_t emitted_q [$];
  int          mismatches = 0;
  int          results_seen = 0;
  bit          no_idle = 1'b0;
  int          quiet_cycles = 0;

  task automatic store_member(input int s, input member_t h);
    logic [32:0] e;
    if (cl_count[s] >= NMB) begin
      cl_ovf[s] = 1'b1;
      return;
    end
    cl_mbr[s*NMB + cl_count[s]] = h;
    cl_count[s]++;
    e = {1'b0, h.start_tick} + {17'b0, h.duration};
    if (e > cl_end[s]) cl_end[s] = e;
  endtask

  task automatic release_slot(input int s);
    cl_valid[s] = 1'b0;
    cl_count[s] = 0;
    cl_end[s] = '0;
    cl_ovf[s] = 1'b0;
  endtask

  // Emit a closed cluster if it is big enough, then free its slot
  task automatic close_cluster(input int s, input bit forced);
    member_out_t r;
    if (cl_count[s] >= min_size) begin
      for (int m = 0; m < cl_count[s]; m++) begin
        r.mbr = cl_mbr[s*NMB + m];
        r.size = 8'(cl_count[s]);
        r.last_grp = (m + 1 == cl_count[s]);
        r.last_run = 1'b0;
        r.ovf = forced || cl_ovf[s];
        emitted_q.insert(emitted_q.size(), r);
      end
    end
    release_slot(s);
  endtask

  task automatic group_hit(input hit_item_t it, output int n_new);
    int   first;
    int   target;
    int   kept [$];
    int   s;
    bit   near;
    int   chan_gap;
    first = emitted_q.size();
    target = -1;
    if (it.req == REQ_FLUSH) begin
      for (int k = 0; k < open_n; k++) close_cluster(cl_order[k], 1'b0);
      open_n = 0;
    end else begin
      for (int k = 0; k < open_n; k++) begin
        s = cl_order[k];
        if ({1'b0, it.hit.start_tick} > cl_end[s] &&
            {1'b0, it.hit.start_tick} - cl_end[s] > {17'b0, tick_lim}) begin
          close_cluster(s, 1'b0);
          continue;
        end
        near = 1'b0;
        for (int m = 0; m < cl_count[s]; m++) begin
          chan_gap = int'(cl_mbr[s*NMB + m].channel) - int'(it.hit.channel);
          if (chan_gap < 0) chan_gap = -chan_gap;
          if (chan_gap <= int'(chan_win)) near = 1'b1;
        end
        if (!near) begin
          kept.insert(kept.size(), s);
        end else if (target < 0) begin
          store_member(s, it.hit);
          target = s;
          kept.insert(kept.size(), s);
        end else begin
          // Fold this cluster into the first match
          for (int m = 0; m < cl_count[s]; m++) store_member(target, cl_mbr[s*NMB + m]);
          if (cl_ovf[s]) cl_ovf[target] = 1'b1;
          release_slot(s);
        end
      end
      open_n = kept.size();
      for (int k = 0; k < open_n; k++) cl_order[k] = kept[k];
      if (target < 0) begin
        if (open_n >= NCL) begin
          close_cluster(cl_order[0], 1'b1);
          for (int k = 1; k < open_n; k++) cl_order[k-1] = cl_order[k];
          open_n--;
        end
        for (s = 0; s < NCL; s++) if (!cl_valid[s]) break;
        if (s < NCL) begin
          release_slot(s);
          cl_valid[s] = 1'b1;
          store_member(s, it.hit);
          cl_order[open_n] = s;
          open_n++;
        end
      end
    end
    n_new = emitted_q.size() - first;
    if (n_new > 0) emitted_q[emitted_q.size()-1].last_run = 1'b1;
  endtask

  // Offer one item after a random gap; hold it until taken, then predict
  task automatic offer_item(input hit_item_t it, output int n_new);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= it.req;
    start_tick <= it.hit.start_tick;
    over_threshold_ticks <= it.hit.duration;
    peak_tick <= it.hit.peak_tick;
    wire_channel <= it.hit.channel;
    charge_sum <= it.hit.charge;
    peak_height <= it.hit.height;
    hit_tag <= it.hit.tag;
    do @(posedge clk); while (!in_ready);
    group_hit(it, n_new);
  endtask

  // Wait for every expected item, let the walk finish, then write registers
  task automatic set_registers(input logic [15:0] tl, input logic [11:0] cw,
                               input logic [7:0] mg);
    in_valid <= 1'b0;
    wait (emitted_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_TICK_LIMIT;
    cfg_wdata <= tl;
    @(posedge clk);
    cfg_addr <= CFG_CHANNEL_WINDOW;
    cfg_wdata <= {4'b0, cw};
    @(posedge clk);
    cfg_addr <= CFG_MIN_GROUP_SIZE;
    cfg_wdata <= {8'b0, mg};
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_lim = tl;
    chan_win = cw;
    min_size = mg;
  endtask

  function automatic hit_item_t make_hit(input logic [31:0] st, input logic [15:0] du,
                                         input logic [15:0] ch, input bit ones);
    hit_item_t it;
    it.req = REQ_HIT;
    it.hit.start_tick = st;
    it.hit.duration = du;
    it.hit.channel = ch;
    it.hit.peak_tick = ones ? '1 : st + 32'd1;
    it.hit.charge = ones ? '1 : 24'(ch) * 24'd3;
    it.hit.height = ones ? '1 : 14'(ch);
    it.hit.tag = ones ? '1 : {16'(st), ch};
    return it;
  endfunction

  function automatic hit_item_t make_flush();
    hit_item_t it;
    it = '0;
    it.req = REQ_FLUSH;
    it.hit.tag = $urandom();
    return it;
  endfunction

  // Compare each delivered item against the oldest expectation
  always @(posedge clk) begin
    member_out_t got;
    member_out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      got.mbr = {out_start_tick, out_over_threshold, out_peak_tick, out_channel,
                 out_charge, out_peak_height, out_tag};
      got.size = group_size;
      got.last_grp = last_of_group;
      got.last_run = last_of_run;
      got.ovf = overflowed;
      if (emitted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: %p", got);
      end else begin
        want = emitted_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls per item, plus one long hold to back up the block
  initial begin
    int  stall;
    bit  held;
    held = 1'b0;
    @(negedge rst);
    forever begin
      if (!held && results_seen >= 30) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    dir_row_t     rows [$];
    hit_item_t    it;
    int           n_new;
    logic [31:0]  now;
    logic [15:0]  chan_base;
    logic [31:0]  step;
    logic [15:0]  tl_set [7] = '{16'd100, 16'd0, 16'd65535, 16'd10, 16'd500, 16'd30, 16'd0};
    logic [11:0]  cw_set [7] = '{12'd20, 12'd0, 12'd4095, 12'd5, 12'd50, 12'd10, 12'd0};
    logic [7:0]   mg_set [7] = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd3, 8'd1, 8'd0};

    tick_lim = 16'd100;
    chan_win = 12'd20;
    min_size = 8'd1;
    open_n = 0;
    for (int s = 0; s < NCL; s++) release_slot(s);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty flush, extremes, full table, merge, full cluster, close by time
    rows.insert(rows.size(), dir_row_t'{make_flush(), 0});
    rows.insert(rows.size(), dir_row_t'{make_hit(32'd0, 16'd0, 16'd0, 1'b0), 0});
    rows.insert(rows.size(), dir_row_t'{make_hit(32'd10, 16'hFFFF, 16'd10, 1'b1), 0});
    rows.insert(rows.size(), dir_row_t'{make_hit(32'd20, 16'd3, 16'd500, 1'b0), 0});
    rows.insert(rows.size(), dir_row_t'{make_hit(32'd30, 16'd3, 16'd1000, 1'b0), 0});
    rows.insert(rows.size(), dir_row_t'{make_hit(32'd40, 16'd3, 16'd2000, 1'b0), 0});
    rows.insert(rows.size(), dir_row_t'{make_hit(32'd50, 16'd3, 16'd3000, 1'b0), 2});
    rows.insert(rows.size(), dir_row_t'{make_flush(), 4});
    rows.insert(rows.size(), dir_row_t'{make_hit(32'd100, 16'd5, 16'd100, 1'b0), 0});
    rows.insert(rows.size(), dir_row_t'{make_hit(32'd100, 16'd5, 16'd140, 1'b0), 0});
    rows.insert(rows.size(), dir_row_t'{make_hit(32'd101, 16'd5, 16'd120, 1'b0), 0});
    for (int k = 0; k < 8; k++)
      rows.insert(rows.size(), dir_row_t'{make_hit(32'd102 + k, 16'd5, 16'd100, 1'b0), 0});
    rows.insert(rows.size(), dir_row_t'{make_hit(32'd200000, 16'd5, 16'd100, 1'b0), 8});
    rows.insert(rows.size(), dir_row_t'{make_hit(32'd200000, 16'd5, 16'hFFFF, 1'b0), 0});
    rows.insert(rows.size(), dir_row_t'{make_flush(), 2});

    foreach (rows[i]) begin
      offer_item(rows[i].item, n_new);
      if (rows[i].n_results >= 0 && n_new != rows[i].n_results) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row %0d: expected %0d items, predicted %0d", i, rows[i].n_results, n_new);
      end
    end

    // Random phases, one register setting each; flush closes every phase
    for (int p = 0; p < 7; p++) begin
      if (p == 6) set_registers(16'($urandom), 12'($urandom), 8'($urandom_range(0, 4)));
      else set_registers(tl_set[p], cw_set[p], mg_set[p]);
      no_idle = (p % 3 == 2);
      now = (p == 3) ? 32'hFFFF_F000 : $urandom_range(0, 32'hF000_0000);
      chan_base = 16'($urandom_range(0, 16'hFF00));
      for (int k = 0; k < 29; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          it = make_flush();
        end else begin
          case ($urandom_range(0, 9))
            0:       step = $urandom_range(0, 5000);
            1, 2:    step = $urandom_range(0, 300);
            default: step = $urandom_range(0, 20);
          endcase
          now = (now > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : now + step;
          it.req = REQ_HIT;
          it.hit.start_tick = now;
          it.hit.duration = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 50));
          it.hit.channel = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                           : chan_base + 16'($urandom_range(0, 60));
          it.hit.peak_tick = $urandom();
          it.hit.charge = 24'($urandom);
          it.hit.height = 14'($urandom);
          it.hit.tag = $urandom();
        end
        offer_item(it, n_new);
      end
      offer_item(make_flush(), n_new);
    end

    in_valid <= 1'b0;
    wait (emitted_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
